### design/checkpoint_hash_barrier_core_defines.svh
// Assertion macros used by the checker file.
// Both sample on clk and are switched off while rst_n is low.
`ifndef CHECKPOINT_HASH_BARRIER_CORE_DEFINES_SVH
`define CHECKPOINT_HASH_BARRIER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CHKBAR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checker: same-cycle rule broken");

// Next-cycle implication.
`define CHKBAR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checker: next-cycle rule broken");

`endif

### design/chkbar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chkbar_pkg;

  // Default geometry
  localparam int SLOTS_DEF            = 8;
  localparam int MIN_PARTICIPANTS_DEF = 2;

  // Command codes
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_SUBMIT = 2'd1,
    CMD_PAUSE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_code_t;

  // Barrier status codes
  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_COLLECTING = 2'd1,
    ST_MATCHED    = 2'd2,
    ST_MISMATCH   = 2'd3
  } bar_status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] close_tick;
    logic [63:0] commit_tick;
    logic [7:0]  required_mask;
    logic [2:0]  slot;
    logic        slot_valid;
    logic [63:0] sub_tick;
    logic        hash_present;
    logic [63:0] snap_hash;
    logic [63:0] bundle_seq;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        pause;
    logic [1:0]  status;
    logic [63:0] read_hash;
    logic [63:0] read_seq;
    logic        read_missing;
  } out_item_t;

  // Datapath to controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      tick_ok;
    logic      count_ok;
    logic      sub_ok;
    logic      filled;
    logic      same_entry;
    logic      complete;
    logic      differs;
  } dp_stat_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        arm;
    logic        fill;
    logic        finish;
    logic        accepted;
    bar_status_t status_nxt;
  } dp_ctl_t;

endpackage

`default_nettype wire

### design/chkbar_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module chkbar_dp #(
  parameter int SLOTS            = chkbar_pkg::SLOTS_DEF,
  parameter int MIN_PARTICIPANTS = chkbar_pkg::MIN_PARTICIPANTS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  chkbar_pkg::in_item_t in_item,
  input  chkbar_pkg::dp_ctl_t  ctl,
  output chkbar_pkg::dp_stat_t stat,
  output chkbar_pkg::out_item_t out_item
);
  import chkbar_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  in_item_t          item_r;
  logic [63:0]       armed_tick_r;
  logic [SLOTS-1:0]  req_r;
  logic [SLOTS-1:0]  filled_r;
  logic              diff_r;
  logic [63:0]       ref_hash_r;
  logic [63:0]       rd_hash_r;
  logic [63:0]       rd_seq_r;
  out_item_t         out_item_r;

  logic [63:0]       hash_mem [SLOTS];
  logic [63:0]       seq_mem  [SLOTS];

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  in_idx;
  logic [SLOTS-1:0]  idx_bit;
  logic [SLOTS-1:0]  mask_cut;
  logic              in_range;
  logic              req_bit;
  logic              filled_bit;
  logic              read_miss;
  logic [63:0]       armed_nxt;
  out_item_t         out_nxt;

  // Count set bits of the required mask
  function automatic logic [CNT_W-1:0] popcnt(input logic [SLOTS-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      c = c + CNT_W'(m[i]);
    end
    return c;
  endfunction

  assign idx        = IDX_W'(item_r.slot);
  assign in_idx     = IDX_W'(in_item.slot);
  assign idx_bit    = SLOTS'(1) << idx;
  assign mask_cut   = SLOTS'(item_r.required_mask);
  assign in_range   = (32'(item_r.slot) < SLOTS);
  assign req_bit    = in_range && req_r[idx];
  assign filled_bit = in_range && filled_r[idx];
  assign read_miss  = !(item_r.slot_valid && filled_bit);

  // Status towards the controller
  always_comb begin
    stat.cmd        = cmd_code_t'(item_r.cmd);
    stat.tick_ok    = (item_r.close_tick >= item_r.commit_tick);
    stat.count_ok   = (32'(popcnt(mask_cut)) >= MIN_PARTICIPANTS);
    stat.sub_ok     = item_r.slot_valid && in_range && item_r.hash_present &&
                      (item_r.sub_tick == armed_tick_r) && req_bit;
    stat.filled     = filled_bit;
    stat.same_entry = (rd_hash_r == item_r.snap_hash) && (rd_seq_r == item_r.bundle_seq);
    stat.complete   = ((req_r & ~(filled_r | idx_bit)) == '0);
    // every hash is checked against the first one stored
    stat.differs    = diff_r || ((|filled_r) && (item_r.snap_hash != ref_hash_r));
  end

  // Assemble the result item
  assign armed_nxt = ctl.arm ? item_r.close_tick : armed_tick_r;

  always_comb begin
    out_nxt              = '0;
    out_nxt.accepted     = ctl.accepted;
    out_nxt.status       = ctl.status_nxt;
    out_nxt.pause        = (ctl.status_nxt != ST_IDLE) &&
                           (item_r.commit_tick >= armed_nxt);
    if (stat.cmd == CMD_READ) begin
      out_nxt.read_missing = read_miss;
      if (!read_miss) begin
        out_nxt.read_hash = rd_hash_r;
        out_nxt.read_seq  = rd_seq_r;
      end
    end
  end

  // Barrier bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_tick_r <= '0;
      req_r        <= '0;
      filled_r     <= '0;
      diff_r       <= 1'b0;
    end else if (ctl.arm) begin
      armed_tick_r <= item_r.close_tick;
      req_r        <= mask_cut;
      filled_r     <= '0;
      diff_r       <= 1'b0;
    end else if (ctl.fill) begin
      filled_r     <= filled_r | idx_bit;
      diff_r       <= stat.differs;
    end
  end

  // Capture the item, hold the first hash, register the result
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
    if (ctl.fill && !(|filled_r)) begin
      ref_hash_r <= item_r.snap_hash;
    end
    if (ctl.finish) begin
      out_item_r <= out_nxt;
    end
  end

  // Slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      hash_mem[idx] <= item_r.snap_hash;
      seq_mem[idx]  <= item_r.bundle_seq;
    end
    if (ctl.capture) begin
      rd_hash_r <= hash_mem[in_idx];
      rd_seq_r  <= seq_mem[in_idx];
    end
  end

  assign out_item = out_item_r;

endmodule

`default_nettype wire

### design/chkbar_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module chkbar_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  output logic                 out_valid,
  input  chkbar_pkg::dp_stat_t stat,
  output chkbar_pkg::dp_ctl_t  ctl
);
  import chkbar_pkg::*;

  typedef enum logic {
    PH_WAIT,
    PH_EXEC
  } phase_t;

  phase_t      phase_r;
  phase_t      phase_nxt;
  bar_status_t status_r;
  logic        out_valid_r;

  assign busy      = (phase_r == PH_EXEC);
  assign out_valid = out_valid_r;

  // Decode the captured command against the barrier status
  always_comb begin
    ctl            = '0;
    ctl.status_nxt = status_r;
    phase_nxt      = phase_r;
    case (phase_r)
      PH_WAIT: begin
        if (start) begin
          ctl.capture = 1'b1;
          phase_nxt   = PH_EXEC;
        end
      end
      PH_EXEC: begin
        ctl.finish = 1'b1;
        phase_nxt  = PH_WAIT;
        case (stat.cmd)
          CMD_BEGIN: begin
            if (status_r == ST_IDLE && stat.tick_ok) begin
              ctl.arm = 1'b1;
              if (stat.count_ok) begin
                ctl.accepted   = 1'b1;
                ctl.status_nxt = ST_COLLECTING;
              end
            end
          end
          CMD_SUBMIT: begin
            if (status_r == ST_COLLECTING && stat.sub_ok) begin
              if (stat.filled) begin
                // resubmit: accept only an identical entry
                ctl.accepted = stat.same_entry;
              end else begin
                ctl.fill     = 1'b1;
                ctl.accepted = 1'b1;
                if (stat.complete) begin
                  ctl.status_nxt = stat.differs ? ST_MISMATCH : ST_MATCHED;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase
  end

  // Hold phase, barrier status and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      status_r    <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      status_r    <= ctl.status_nxt;
      out_valid_r <= ctl.finish;
    end
  end

endmodule

`default_nettype wire

### design/checkpoint_hash_barrier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Save barrier over up to SLOTS participant slots.
// Input channel: in_item is taken at a rising edge where start is high and
// busy is low. Commands: begin (arm for a target tick and a slot mask),
// submit (store a slot's hash and bundle sequence), pause query and read of
// a stored submission.
// Result channel: every command gives exactly one out_item, shown for one
// cycle with out_valid high; the receiver cannot hold it off.
// Timing: the item is captured and the slot store read on the accept edge;
// the next edge decides and updates the barrier, and out_valid is high in
// the cycle after that. busy is high for the one decision cycle, so the
// core takes no new item until it has decided the last one; that decision
// cycle is set by the registered read of the slot store.
// Matching compares each new hash with the first stored one, so completion
// costs one 64-bit compare regardless of slot count.
// Reset (rst_n low, synchronous) returns the barrier to idle with no slots
// required or filled; stored hashes and sequences are not cleared and are
// only read for filled slots. Nothing but reset leaves matched or mismatch.
module checkpoint_hash_barrier_core #(
  parameter int SLOTS            = chkbar_pkg::SLOTS_DEF,
  parameter int MIN_PARTICIPANTS = chkbar_pkg::MIN_PARTICIPANTS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  chkbar_pkg::in_item_t  in_item,
  output logic                  out_valid,
  output chkbar_pkg::out_item_t out_item
);
  import chkbar_pkg::*;

  dp_stat_t stat;
  dp_ctl_t  ctl;

  chkbar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .ctl       (ctl)
  );

  chkbar_dp #(
    .SLOTS            (SLOTS),
    .MIN_PARTICIPANTS (MIN_PARTICIPANTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

### design/chkbar_checker.sv
`timescale 1ns / 1ps
`include "checkpoint_hash_barrier_core_defines.svh"
`default_nettype none

module chkbar_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   start,
  input wire                   busy,
  input wire                   out_valid,
  input chkbar_pkg::out_item_t out_item
);
  import chkbar_pkg::*;

  // An accepted item makes busy high in the next cycle
  `CHKBAR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // Its result strobe follows once the busy decision phase is over
  `CHKBAR_ASSERT_IMP(a_accept_result, start && !busy, ##2 out_valid)
  // One result per item, never two in a row
  `CHKBAR_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  // An idle barrier never asks for a pause
  `CHKBAR_ASSERT_IMP(a_idle_no_pause, out_valid && out_item.status == ST_IDLE, !out_item.pause)

endmodule

bind checkpoint_hash_barrier_core chkbar_checker u_chk (.*);

`default_nettype wire

### tb/tb_checkpoint_hash_barrier_core.sv
`timescale 1ns / 1ps

module tb_checkpoint_hash_barrier_core;
  import chkbar_pkg::*;

  localparam int STALL_LIMIT = 400;
  localparam int NSLOT       = SLOTS_DEF;

  // Barrier predictor and the queue of replies it still expects
  class barrier_tracker;
    bar_status_t bar_state;
    logic [63:0] armed;
    logic [7:0]  req_slots;
    logic [7:0]  filled;
    logic [63:0] slot_hash [NSLOT];
    logic [63:0] slot_seq  [NSLOT];
    out_item_t   reply_q[$];
    int          errors;
    int          n_cmds;
    int          n_accepted;
    int          n_found;

    function new();
      bar_state = ST_IDLE;
      armed     = '0;
      req_slots = '0;
      filled    = '0;
      errors    = 0;
      n_cmds    = 0;
      n_accepted = 0;
      n_found   = 0;
    endfunction

    // Settle to matched or mismatch once every required slot has a hash
    function void settle();
      int first;
      bit same;
      first = -1;
      same  = 1'b1;
      if ((req_slots & ~filled) != 0) return;
      for (int i = 0; i < NSLOT; i++) begin
        if (req_slots[i]) begin
          if (first < 0) first = i;
          else if (slot_hash[i] != slot_hash[first]) same = 1'b0;
        end
      end
      bar_state = same ? ST_MATCHED : ST_MISMATCH;
    endfunction

    // Work out the reply to one accepted command and queue it
    function void note_command(in_item_t it);
      out_item_t e;
      int s;
      e = '0;
      s = int'(it.slot);
      n_cmds++;
      case (cmd_code_t'(it.cmd))
        CMD_BEGIN: begin
          if (bar_state == ST_IDLE && it.close_tick >= it.commit_tick) begin
            armed     = it.close_tick;
            filled    = '0;
            req_slots = it.required_mask;
            if ($countones(req_slots) >= MIN_PARTICIPANTS_DEF) begin
              bar_state  = ST_COLLECTING;
              e.accepted = 1'b1;
            end
          end
        end
        CMD_SUBMIT: begin
          if (bar_state == ST_COLLECTING && it.sub_tick == armed && it.hash_present &&
              it.slot_valid && req_slots[s]) begin
            if (filled[s]) begin
              e.accepted = (slot_hash[s] == it.snap_hash) && (slot_seq[s] == it.bundle_seq);
            end else begin
              slot_hash[s] = it.snap_hash;
              slot_seq[s]  = it.bundle_seq;
              filled[s]    = 1'b1;
              e.accepted   = 1'b1;
              settle();
            end
          end
        end
        CMD_READ: begin
          if (it.slot_valid && filled[s]) begin
            e.read_hash = slot_hash[s];
            e.read_seq  = slot_seq[s];
            n_found++;
          end else begin
            e.read_missing = 1'b1;
          end
        end
        default: ;
      endcase
      if (e.accepted) n_accepted++;
      e.pause  = (bar_state != ST_IDLE) && (it.commit_tick >= armed);
      e.status = bar_state;
      reply_q.push_back(e);
    endfunction

    // Compare one reply with the oldest expectation
    function void check_reply(out_item_t got);
      out_item_t e;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected reply with nothing outstanding: %p", got);
        return;
      end
      e = reply_q.pop_front();
      if (got.accepted !== e.accepted || got.pause !== e.pause ||
          got.status !== e.status || got.read_hash !== e.read_hash ||
          got.read_seq !== e.read_seq || got.read_missing !== e.read_missing) begin
        errors++;
        if (errors <= 10) begin
          $display("reply mismatch: exp acc=%0b pause=%0b st=%0d hash=%h seq=%h miss=%0b",
                   e.accepted, e.pause, e.status, e.read_hash, e.read_seq,
                   e.read_missing);
          $display("                got acc=%0b pause=%0b st=%0d hash=%h seq=%h miss=%0b",
                   got.accepted, got.pause, got.status, got.read_hash, got.read_seq,
                   got.read_missing);
        end
      end
    endfunction

    function int pending();
      return reply_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  barrier_tracker tracker;
  int          stall_cycles;
  int          burst_left;
  logic [63:0] armed_t;
  logic [63:0] common_hash;
  logic [7:0]  arm_mask;
  int          first_slot;
  int          last_slot;
  logic [7:0]  gen_sent;
  logic [63:0] gen_hash [NSLOT];
  logic [63:0] gen_seq  [NSLOT];
  bit          hold_last;

  checkpoint_hash_barrier_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Check replies and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_reply(out_item);
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_checkpoint_hash_barrier_core failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Committed tick near the armed tick, at the extremes, or anywhere
  function automatic logic [63:0] pick_commit();
    case ($urandom_range(0, 5))
      0: return armed_t - 64'd1;
      1: return armed_t;
      2: return armed_t + 64'd1;
      3: return '0;
      4: return '1;
      default: return rand64();
    endcase
  endfunction

  // Fully random command, never a submit for the armed tick
  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd            = cmd_code_t'($urandom_range(0, 3));
    it.close_tick     = rand64();
    it.commit_tick    = pick_commit();
    it.required_mask  = 8'($urandom_range(0, 255));
    it.slot           = 3'($urandom_range(0, NSLOT - 1));
    it.slot_valid     = 1'($urandom_range(0, 1));
    it.sub_tick       = rand64();
    it.hash_present   = 1'($urandom_range(0, 1));
    it.snap_hash      = rand64();
    it.bundle_seq     = rand64();
    if (it.sub_tick == armed_t) it.sub_tick[0] = ~it.sub_tick[0];
    return it;
  endfunction

  // Well-formed submit for the armed tick
  function automatic in_item_t submit_item(int s, logic [63:0] h, logic [63:0] q);
    in_item_t it;
    it              = noise_item();
    it.cmd          = CMD_SUBMIT;
    it.slot         = 3'(s);
    it.slot_valid   = 1'b1;
    it.hash_present = 1'b1;
    it.sub_tick     = armed_t;
    it.snap_hash    = h;
    it.bundle_seq   = q;
    return it;
  endfunction

  function automatic in_item_t query_item(cmd_code_t c, int s, bit v, logic [63:0] ct);
    in_item_t it;
    it                = noise_item();
    it.cmd            = c;
    it.slot           = 3'(s);
    it.slot_valid     = v;
    it.commit_tick    = ct;
    return it;
  endfunction

  function automatic in_item_t begin_item(logic [63:0] tt, logic [63:0] ct, logic [7:0] m);
    in_item_t it;
    it                = noise_item();
    it.cmd            = CMD_BEGIN;
    it.close_tick     = tt;
    it.commit_tick    = ct;
    it.required_mask  = m;
    return it;
  endfunction

  // Offer one item, hold it until taken, then pace the sender in bursts
  task automatic issue(input in_item_t it);
    int gap;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_command(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every reply has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Idle noise: begins are kept to ones the barrier must refuse
  task automatic idle_step();
    in_item_t it;
    it = noise_item();
    if (it.cmd == CMD_BEGIN) begin
      if ($urandom_range(0, 1)) begin
        it.required_mask = $urandom_range(0, 1) ? 8'h00 : (8'h01 << $urandom_range(0, 7));
      end else begin
        if (it.commit_tick == 0) it.commit_tick = 64'd1;
        it.close_tick = it.commit_tick - 64'd1 - 64'($urandom_range(0, 3));
        if (it.close_tick >= it.commit_tick) it.close_tick = '0;
      end
    end
    issue(it);
  endtask

  // One random command while armed or after settling
  task automatic barrier_step();
    in_item_t it;
    int s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // submit for a required slot; the held-back slot is never filled here
      do s = $urandom_range(0, NSLOT - 1);
      while (!arm_mask[s] || (hold_last && s == last_slot));
      if (!gen_sent[s]) begin
        gen_hash[s] = ($urandom_range(0, 9) == 0) ? rand64() : common_hash;
        gen_seq[s]  = rand64();
        gen_sent[s] = 1'b1;
        it = submit_item(s, gen_hash[s], gen_seq[s]);
      end else begin
        it = submit_item(s, gen_hash[s], gen_seq[s]);
        case ($urandom_range(0, 3))
          0: it.snap_hash = it.snap_hash ^ (64'd1 << $urandom_range(0, 63));
          1: it.bundle_seq = it.bundle_seq ^ (64'd1 << $urandom_range(0, 63));
          default: ;
        endcase
      end
    end else if (pick < 62) begin
      // broken submit: one rule violated
      s  = $urandom_range(0, NSLOT - 1);
      it = submit_item(s, rand64(), rand64());
      case ($urandom_range(0, 3))
        0: it.hash_present = 1'b0;
        1: it.slot_valid   = 1'b0;
        2: begin
          if (arm_mask != 8'hFF) begin
            do s = $urandom_range(0, NSLOT - 1); while (arm_mask[s]);
            it.slot = 3'(s);
          end else begin
            it.sub_tick = armed_t ^ (64'd1 << $urandom_range(0, 63));
          end
        end
        default: it.sub_tick = armed_t ^ (64'd1 << $urandom_range(0, 63));
      endcase
    end else if (pick < 77) begin
      it = query_item(CMD_READ, $urandom_range(0, NSLOT - 1), $urandom_range(0, 7) != 0,
                      pick_commit());
    end else if (pick < 90) begin
      it = query_item(CMD_PAUSE, $urandom_range(0, NSLOT - 1), 1'($urandom_range(0, 1)),
                      pick_commit());
    end else begin
      it = noise_item();
      it.cmd = CMD_BEGIN;
      if ($urandom_range(0, 1)) begin
        it.commit_tick    = '0;
        it.required_mask  = 8'hFF;
      end
    end
    issue(it);
  endtask

  initial begin
    logic [63:0] close_hash;
    tracker      = new();
    stall_cycles = 0;
    burst_left   = 0;
    gen_sent     = '0;
    hold_last    = 1'b1;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    armed_t      = rand64();
    common_hash  = rand64();
    do arm_mask = 8'($urandom_range(0, 255));
    while ($countones(arm_mask) < 2 || arm_mask == 8'hFF);
    first_slot = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (arm_mask[i]) begin
        if (first_slot < 0) first_slot = i;
        last_slot = i;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle: queries, reads and submits do nothing, begins are refused
    issue(query_item(CMD_PAUSE, 0, 1'b1, '1));
    issue(query_item(CMD_READ, 0, 1'b1, '0));
    issue(query_item(CMD_READ, NSLOT - 1, 1'b0, '1));
    issue(submit_item(0, '1, '0));
    issue(begin_item('0, 64'd1, 8'hFF));
    issue(begin_item('1, '1, 8'h01));
    issue(begin_item('0, '0, 8'h00));
    issue(begin_item('1, '0, 8'h80));
    issue(query_item(CMD_PAUSE, NSLOT - 1, 1'b1, '1));
    repeat (80) idle_step();
    drain();

    // Arm with target equal to the committed tick
    issue(begin_item(armed_t, armed_t, arm_mask));
    issue(begin_item(armed_t, '0, 8'hFF));
    begin
      in_item_t it;
      it = submit_item(first_slot, common_hash, '1);
      it.sub_tick = armed_t + 64'd1;
      issue(it);
      it = submit_item(first_slot, common_hash, '1);
      it.hash_present = 1'b0;
      issue(it);
      it = submit_item(first_slot, common_hash, '1);
      it.slot_valid = 1'b0;
      issue(it);
      if (arm_mask != 8'hFF) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!arm_mask[i]) it = submit_item(i, common_hash, '1);
        end
        issue(it);
      end
    end
    // First fill, equal resubmit, then resubmits that differ
    gen_hash[first_slot] = common_hash;
    gen_seq[first_slot]  = '1;
    gen_sent[first_slot] = 1'b1;
    issue(submit_item(first_slot, common_hash, '1));
    issue(submit_item(first_slot, common_hash, '1));
    issue(submit_item(first_slot, '0, '1));
    issue(submit_item(first_slot, common_hash, '0));
    issue(query_item(CMD_READ, first_slot, 1'b1, armed_t));
    issue(query_item(CMD_READ, first_slot, 1'b0, armed_t));
    issue(query_item(CMD_READ, last_slot, 1'b1, armed_t));
    issue(query_item(CMD_PAUSE, 0, 1'b1, armed_t - 64'd1));
    issue(query_item(CMD_PAUSE, 0, 1'b1, armed_t));
    issue(query_item(CMD_PAUSE, 0, 1'b1, armed_t + 64'd1));
    issue(query_item(CMD_PAUSE, 0, 1'b1, '0));
    issue(query_item(CMD_PAUSE, 0, 1'b1, '1));

    // Collect with one required slot held back
    repeat (470) barrier_step();

    // Close the barrier: fill what is left, the held-back slot last
    for (int i = 0; i < NSLOT; i++) begin
      if (arm_mask[i] && !gen_sent[i] && i != last_slot) begin
        gen_hash[i] = common_hash;
        gen_seq[i]  = rand64();
        gen_sent[i] = 1'b1;
        issue(submit_item(i, gen_hash[i], gen_seq[i]));
      end
    end
    close_hash          = ($urandom_range(0, 3) == 0) ? rand64() : common_hash;
    gen_hash[last_slot] = close_hash;
    gen_seq[last_slot]  = rand64();
    gen_sent[last_slot] = 1'b1;
    hold_last           = 1'b0;
    issue(submit_item(last_slot, close_hash, gen_seq[last_slot]));
    drain();

    // Settled: everything but reads and queries is refused
    issue(query_item(CMD_READ, last_slot, 1'b1, armed_t));
    issue(begin_item('1, '0, 8'hFF));
    issue(submit_item(last_slot, close_hash, gen_seq[last_slot]));
    issue(query_item(CMD_PAUSE, 0, 1'b1, armed_t));
    repeat (150) barrier_step();

    drain();
    repeat (6) @(posedge clk);
    $display("barrier run: %0d commands, %0d begin/submit taken, %0d reads found an entry",
             tracker.n_cmds, tracker.n_accepted, tracker.n_found);
    $display("required mask %h, barrier settled as %s, %0d reply errors",
             arm_mask, tracker.bar_state.name(), tracker.errors);
    if (tracker.pending() != 0)
      $display("replies still outstanding: %0d", tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_checkpoint_hash_barrier_core passed");
    end else begin
      $display("tb_checkpoint_hash_barrier_core failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/chkbar_pkg.sv
design/chkbar_dp.sv
design/chkbar_ctrl.sv
design/checkpoint_hash_barrier_core.sv
design/chkbar_checker.sv
tb/tb_checkpoint_hash_barrier_core.sv
